// ----- hw/rtl/epcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcc_pkg
// Shared types and constants of the Euler path / circuit checker.
// ----------------------------------------------------------------------------
package epcc_pkg;

	localparam int MAX_VERTICES_DEF = 32;

	localparam int OP_W      = 2;
	localparam int VTX_W     = 5;
	localparam int VCOUNT_W  = 6;
	localparam int VERDICT_W = 2;
	localparam int ODD_W     = 6;
	// common width for vertex compares, holds any count up to 64
	localparam int CMP_W     = 8;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 6'd32;

	// register index, taken from paddr above the byte offset
	localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_EDGE = 2'd0,
		OP_EVALUATE = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_NONE  = 2'd0,
		VERDICT_PATH  = 2'd1,
		VERDICT_CYCLE = 2'd2
	} verdict_t;

	typedef struct packed {
		logic capture;     // latch edge ends of the accepted word
		logic write_a;     // set adjacency bit in row of first end
		logic write_b;     // set adjacency bit in row of second end
		logic clear;       // empty the graph
		logic cnt_init;    // start an evaluation
		logic cnt_step;    // odd-count / start search, one vertex
		logic walk_issue;  // read row of next pending vertex
		logic walk_merge;  // fold that row into the reached set
	} epcc_cmd_t;

	typedef struct packed {
		logic edge_ok;     // both ends in use
		logic self_loop;
		logic cnt_done;    // sweep went past the last vertex in use
		logic walk_pend;   // a reached vertex is not expanded yet
	} epcc_stat_t;

endpackage

// ----- hw/rtl/epcc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcc_in_if
// Input word channel: graph operation and edge ends.
// ----------------------------------------------------------------------------
interface epcc_in_if import epcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [VTX_W-1:0] first_vertex;
	logic [VTX_W-1:0] second_vertex;

	modport source (output valid, output op, output first_vertex, output second_vertex,
		input ready);
	modport sink (input valid, input op, input first_vertex, input second_vertex,
		output ready);
endinterface

// ----- hw/rtl/epcc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcc_out_if
// Result word channel: verdict and odd-degree vertex count.
// ----------------------------------------------------------------------------
interface epcc_out_if import epcc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic [ODD_W-1:0]     odd_vertices;

	modport source (output valid, output verdict, output odd_vertices, input ready);
	modport sink (input valid, input verdict, input odd_vertices, output ready);
endinterface

// ----- hw/rtl/euler_path_circuit_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_path_circuit_check
// Euler path / circuit test of an undirected graph loaded edge by edge.
//
//  channel | dir | payload                                   | words
//  --------+-----+-------------------------------------------+-----------------
//  item    | in  | op, first_vertex, second_vertex           | one per op
//  result  | out | verdict, odd_vertices                     | one per evaluate
//  APB     | in  | vertex_count at byte address 0            | config writes
//
// One word at a time. Add edge steps through ST_EDGE_A and ST_EDGE_B (only
// ST_EDGE_A for a self loop or a dropped edge); clear and unused ops are
// done in ST_IDLE. Evaluate runs the odd-count sweep, which visits one
// vertex a cycle, then the walk, which reads one adjacency row at a time,
// an issue state then a merge state, through the single memory read port.
// Reset empties the graph at once (row valid bits) and sets vertex_count 32.
// A finished result waits in the output register while new words are taken;
// an evaluate stalls at its end only while that register is full and not taken.
// ----------------------------------------------------------------------------
module euler_path_circuit_check import epcc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	epcc_in_if.sink               item,
	epcc_out_if.source            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [VCOUNT_W-1:0]  vcount_q;
	logic                 out_valid_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic [ODD_W-1:0]     odd_q;

	epcc_cmd_t            cmd;
	epcc_stat_t           stat;
	logic                 emit;
	logic                 out_free;
	logic [VERDICT_W-1:0] dp_verdict;
	logic [ODD_W-1:0]     dp_odd;
	logic                 reg_hit;

	// config register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT);
	assign prdata  = reg_hit ? {{(APB_DATA_W-VCOUNT_W){1'b0}}, vcount_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vcount_q <= VCOUNT_RST;
		else if (psel && penable && pwrite && reg_hit)
			vcount_q <= pwdata[VCOUNT_W-1:0];
	end

	epcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.op       (item.op),
		.in_ready (item.ready),
		.stat     (stat),
		.out_free (out_free),
		.emit     (emit),
		.cmd      (cmd)
	);

	epcc_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.vertex_count  (vcount_q),
		.first_vertex  (item.first_vertex),
		.second_vertex (item.second_vertex),
		.verdict       (dp_verdict),
		.odd_vertices  (dp_odd)
	);

	// output word register
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			verdict_q <= dp_verdict;
			odd_q     <= dp_odd;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.verdict      = verdict_q;
	assign result.odd_vertices = odd_q;

endmodule

// ----- hw/rtl/epcc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcc_ctrl
// Sequencer: edge load, odd-count sweep, reachability walk, result hand-off.
// ----------------------------------------------------------------------------
module epcc_ctrl import epcc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] op,
	output logic            in_ready,
	input  epcc_stat_t      stat,
	input  logic            out_free,
	output logic            emit,
	output epcc_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_COUNT,
		ST_WALK_RD,
		ST_WALK_MRG,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		emit      = 1'b0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (op)
						OP_ADD_EDGE: state_nxt = ST_EDGE_A;
						OP_EVALUATE: begin
							cmd.cnt_init = 1'b1;
							state_nxt    = ST_COUNT;
						end
						OP_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_EDGE_A: begin
				cmd.write_a = stat.edge_ok;
				state_nxt   = (stat.edge_ok && !stat.self_loop) ? ST_EDGE_B : ST_IDLE;
			end
			ST_EDGE_B: begin
				cmd.write_b = 1'b1;
				state_nxt   = ST_IDLE;
			end
			ST_COUNT: begin
				if (stat.cnt_done)
					state_nxt = ST_WALK_RD;
				else
					cmd.cnt_step = 1'b1;
			end
			ST_WALK_RD: begin
				if (stat.walk_pend) begin
					cmd.walk_issue = 1'b1;
					state_nxt      = ST_WALK_MRG;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_WALK_MRG: begin
				cmd.walk_merge = 1'b1;
				state_nxt      = ST_WALK_RD;
			end
			ST_FINISH: begin
				if (out_free) begin
					emit      = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

// ----- hw/rtl/epcc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcc_dp
// Graph store and evaluation datapath: adjacency memory, parity and touch
// flags, odd counter and reached / expanded vertex sets.
// ----------------------------------------------------------------------------
module epcc_dp import epcc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  epcc_cmd_t            cmd,
	output epcc_stat_t           stat,
	input  logic [VCOUNT_W-1:0]  vertex_count,
	input  logic [VTX_W-1:0]     first_vertex,
	input  logic [VTX_W-1:0]     second_vertex,
	output logic [VERDICT_W-1:0] verdict,
	output logic [ODD_W-1:0]     odd_vertices
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int VW = $clog2(MAX_VERTICES + 1);

	typedef logic [MAX_VERTICES-1:0] row_t;

	// adjacency rows; a row is only meaningful once its valid bit is set
	row_t mem [MAX_VERTICES];

	row_t row_vld_q;
	row_t odd_q;
	row_t touch_q;
	row_t reached_q;
	row_t expanded_q;
	row_t rd_row_q;
	logic rd_vld_q;

	logic [VTX_W-1:0] a_q;
	logic [VTX_W-1:0] b_q;
	logic [VW-1:0]    idx_q;
	logic [VW-1:0]    oddcnt_q;
	logic             start_q;

	logic [CMP_W-1:0] vc_w;
	logic [CMP_W-1:0] n_w;
	logic [CMP_W-1:0] a_w;
	logic [CMP_W-1:0] b_w;
	logic [CMP_W-1:0] idx_w;
	logic [IW-1:0]    a_i;
	logic [IW-1:0]    b_i;
	logic [IW-1:0]    idx_i;
	row_t             mask;
	row_t             pend;
	logic [IW-1:0]    pick;
	logic             wr_en;
	logic [IW-1:0]    wr_row;
	logic [IW-1:0]    wr_col;
	logic             linked;

	// vertices in use: vertex_count clipped to the store depth
	assign vc_w  = {{(CMP_W-VCOUNT_W){1'b0}}, vertex_count};
	assign n_w   = (vc_w > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES) : vc_w;
	assign a_w   = {{(CMP_W-VTX_W){1'b0}}, a_q};
	assign b_w   = {{(CMP_W-VTX_W){1'b0}}, b_q};
	assign idx_w = {{(CMP_W-VW){1'b0}}, idx_q};
	assign a_i   = a_w[IW-1:0];
	assign b_i   = b_w[IW-1:0];
	assign idx_i = idx_q[IW-1:0];

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++)
			mask[i] = (CMP_W'(i) < n_w);
	end

	assign pend = reached_q & ~expanded_q;

	// lowest pending vertex
	always_comb begin
		pick = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--)
			if (pend[i])
				pick = IW'(i);
	end

	assign stat.edge_ok   = (a_w < n_w) && (b_w < n_w);
	assign stat.self_loop = (a_q == b_q);
	assign stat.cnt_done  = (idx_w >= n_w);
	assign stat.walk_pend = |pend;

	assign wr_en  = cmd.write_a | cmd.write_b;
	assign wr_row = cmd.write_a ? a_i : b_i;
	assign wr_col = cmd.write_a ? b_i : a_i;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (row_vld_q[wr_row])
				mem[wr_row][wr_col] <= 1'b1;
			else
				mem[wr_row] <= row_t'(1) << wr_col;
		end
		if (cmd.walk_issue) begin
			rd_row_q <= mem[pick];
			rd_vld_q <= row_vld_q[pick];
		end
		if (cmd.capture) begin
			a_q <= first_vertex;
			b_q <= second_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			odd_q      <= '0;
			touch_q    <= '0;
			reached_q  <= '0;
			expanded_q <= '0;
			idx_q      <= '0;
			oddcnt_q   <= '0;
			start_q    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				row_vld_q <= '0;
				odd_q     <= '0;
				touch_q   <= '0;
				reached_q <= '0;
			end
			if (cmd.write_a) begin
				row_vld_q[a_i] <= 1'b1;
				touch_q[a_i]   <= 1'b1;
				touch_q[b_i]   <= 1'b1;
				// self loop adds two to the degree: parity unchanged
				if (a_i != b_i) begin
					odd_q[a_i] <= ~odd_q[a_i];
					odd_q[b_i] <= ~odd_q[b_i];
				end
			end
			if (cmd.write_b)
				row_vld_q[b_i] <= 1'b1;
			if (cmd.cnt_init) begin
				idx_q      <= '0;
				oddcnt_q   <= '0;
				reached_q  <= '0;
				expanded_q <= '0;
				start_q    <= 1'b0;
			end
			if (cmd.cnt_step) begin
				idx_q    <= idx_q + VW'(1);
				oddcnt_q <= oddcnt_q + VW'(odd_q[idx_i]);
				// walk starts at the lowest touched vertex in use
				if (touch_q[idx_i] && !start_q) begin
					reached_q <= row_t'(1) << idx_i;
					start_q   <= 1'b1;
				end
			end
			if (cmd.walk_issue)
				expanded_q[pick] <= 1'b1;
			if (cmd.walk_merge && rd_vld_q)
				reached_q <= reached_q | (rd_row_q & mask);
		end
	end

	assign linked = ((touch_q & mask & ~reached_q) == '0);

	always_comb begin
		verdict = VERDICT_NONE;
		if (linked && oddcnt_q == VW'(0))
			verdict = VERDICT_CYCLE;
		else if (linked && oddcnt_q == VW'(2))
			verdict = VERDICT_PATH;
	end

	assign odd_vertices = ODD_W'(oddcnt_q);

endmodule
